>>> rtl/blu_pkg.sv
`timescale 1ns / 1ps

package blu_pkg;

  // Default sizes of the stores
  localparam int DIM_MAX_DEF   = 32;
  localparam int UPPER_MAX_DEF = 4;
  localparam int LOWER_MAX_DEF = 4;

  // Field widths
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 32;
  localparam int DIM_W   = 6;
  localparam int BAND_W  = 3;
  localparam int ST_W    = 2;
  localparam int CFGA_W  = 2;

  // Q16.16 one
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_WR_ENTRY = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RD_ENTRY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WR_RHS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FACTOR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SOLVE    = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_PIVOT = 2'd2;

  // Register indexes
  localparam logic [CFGA_W-1:0] CFG_DIM   = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_UPPER = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_LOWER = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] num;
    logic signed [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quot;
  } div_rsp_t;

  // Clamp a wide value into the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  // Shift a full product down by 16, round to nearest, ties away from zero
  function automatic logic signed [63:0] mulq_rnd(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    mag = p[63] ? (~p + 64'd1) : p;
    q   = (mag + 64'd32768) >> 16;
    return p[63] ? $signed(~q + 64'd1) : $signed(q);
  endfunction

endpackage

>>> rtl/blu_div.sv
`timescale 1ns / 1ps

// Restoring divider: round(a * 2^16 / b), ties away from zero, saturated.
// One quotient bit per cycle.
module blu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  blu_pkg::div_req_t  req,
  output blu_pkg::div_rsp_t  rsp
);

  localparam int NW = 49;
  localparam int DW = 33;

  logic [NW-1:0] n_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic          neg_r;
  logic          busy_r;
  logic          fin_r;
  logic [5:0]    cnt_r;

  logic [31:0]   ma;
  logic [31:0]   mb;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  always_comb begin
    ma    = req.num[31] ? (~req.num + 32'd1) : req.num;
    mb    = req.den[31] ? (~req.den + 32'd1) : req.den;
    trial = {rem_r, n_r[NW-1]};
    diff  = trial - {1'b0, d_r};
    take  = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= {ma, 17'b0} + {17'b0, mb};
      d_r   <= {mb, 1'b0};
      rem_r <= '0;
      neg_r <= req.num[31] ^ req.den[31];
    end else if (busy_r) begin
      rem_r <= take ? diff[DW-1:0] : trial[DW-1:0];
      n_r   <= {n_r[NW-2:0], take};
    end
  end

  always_comb begin
    rsp.done = fin_r;
    if (!neg_r) begin
      rsp.quot = (n_r > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(n_r[31:0]);
    end else begin
      rsp.quot = (n_r > 49'h0_8000_0000) ? 32'sh8000_0000 : $signed(~n_r[31:0] + 32'd1);
    end
  end

endmodule

>>> rtl/band_matrix_lu_solver_core.sv
`timescale 1ns / 1ps

// Banded LU solver, signed Q16.16. Entry writes and rhs writes take one
// transaction each and answer with one result; a new one is taken every cycle
// the result side keeps up. An entry read goes through a wait state for the
// registered store read and holds in_tready low while in it. Factor and solve
// hold in_tready low while a small sequencer walks the band through one shared
// 32x32 multiplier and one bit-serial divider. Factor time is dominated by one
// division per row and one per eliminated entry; solve adds the forward and
// backward substitutions and then emits the solution one element at a time,
// waiting while a result is stalled. After reset a clearing pass zeroes the
// band and rhs stores, one slot per cycle across the deeper of the two band
// stores (160 slots at the default sizes); in_tready stays low until it ends.
// No pivoting: a zero pivot stops the operation and returns a single result
// with the pivot status.
module band_matrix_lu_solver_core #(
  parameter int DIM_MAX   = blu_pkg::DIM_MAX_DEF,
  parameter int UPPER_MAX = blu_pkg::UPPER_MAX_DEF,
  parameter int LOWER_MAX = blu_pkg::LOWER_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
  input  logic [3:0]  in_tuser,   // req_type[2:0], already_factored[3]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value[31:0], result_index[36:32], zero pad
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CW  = $clog2(DIM_MAX + 1);   // counters reach DIM_MAX
  localparam int IW  = $clog2(DIM_MAX);
  localparam int BW  = CW + 4;
  localparam int UD  = (UPPER_MAX + 1) * DIM_MAX;
  localparam int LD  = (LOWER_MAX + 1) * DIM_MAX;
  localparam int UAW = $clog2(UD);
  localparam int LAW = $clog2(LD);
  localparam int CLR_N = (UD > LD) ? UD : LD;
  localparam int CLR_W = $clog2(CLR_N);

  // Sequencer states
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_RDW    = 6'd1;
  localparam logic [5:0] S_FS_I   = 6'd2;
  localparam logic [5:0] S_FS_D   = 6'd3;
  localparam logic [5:0] S_FS_DIV = 6'd4;
  localparam logic [5:0] S_FS_J   = 6'd5;
  localparam logic [5:0] S_FS_JM  = 6'd6;
  localparam logic [5:0] S_FS_JR  = 6'd7;
  localparam logic [5:0] S_E_K    = 6'd8;
  localparam logic [5:0] S_E_I    = 6'd9;
  localparam logic [5:0] S_E_P    = 6'd10;
  localparam logic [5:0] S_E_PW   = 6'd11;
  localparam logic [5:0] S_E_DIV  = 6'd12;
  localparam logic [5:0] S_E_J    = 6'd13;
  localparam logic [5:0] S_E_JM   = 6'd14;
  localparam logic [5:0] S_E_JR   = 6'd15;
  localparam logic [5:0] S_SF_I   = 6'd16;
  localparam logic [5:0] S_SF_R   = 6'd17;
  localparam logic [5:0] S_SF_L   = 6'd18;
  localparam logic [5:0] S_SF_L2  = 6'd19;
  localparam logic [5:0] S_SF_J   = 6'd20;
  localparam logic [5:0] S_SF_JM  = 6'd21;
  localparam logic [5:0] S_SF_JA  = 6'd22;
  localparam logic [5:0] S_SB_I   = 6'd23;
  localparam logic [5:0] S_SB_D   = 6'd24;
  localparam logic [5:0] S_SB_J   = 6'd25;
  localparam logic [5:0] S_SB_JM  = 6'd26;
  localparam logic [5:0] S_SB_JA  = 6'd27;
  localparam logic [5:0] S_SB_W   = 6'd28;
  localparam logic [5:0] S_SB_DIV = 6'd29;
  localparam logic [5:0] S_EM_RD  = 6'd30;
  localparam logic [5:0] S_EM_OUT = 6'd31;
  localparam logic [5:0] S_CLR    = 6'd32;

  // ---------------------------------------------------------------- config
  logic [5:0] dim_r;
  logic [2:0] up_r;
  logic [2:0] lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 6'd32;
      up_r  <= 3'd1;
      lo_r  <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        blu_pkg::CFG_DIM:   dim_r <= cfg_wdata;
        blu_pkg::CFG_UPPER: up_r  <= cfg_wdata[2:0];
        blu_pkg::CFG_LOWER: lo_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Effective dimension and band widths after clamping
  logic [CW-1:0] n_eff;
  logic [CW-1:0] nm1;
  logic [2:0]    nu;
  logic [2:0]    nl;

  always_comb begin
    if (dim_r == 6'd0) n_eff = CW'(1);
    else if (32'(dim_r) > DIM_MAX) n_eff = CW'(DIM_MAX);
    else n_eff = CW'(dim_r);
    nm1 = n_eff - CW'(1);
    nu  = (32'(up_r) > UPPER_MAX) ? 3'(UPPER_MAX) : up_r;
    nl  = (32'(lo_r) > LOWER_MAX) ? 3'(LOWER_MAX) : lo_r;
  end

  function automatic logic [CW-1:0] lo_b(input logic [CW-1:0] x, input logic [2:0] b);
    return (BW'(x) < BW'(b)) ? '0 : (x - CW'(b));
  endfunction

  function automatic logic [CW-1:0] hi_b(input logic [CW-1:0] x, input logic [2:0] b,
                                         input logic [CW-1:0] top);
    logic [BW-1:0] s;
    s = BW'(x) + BW'(b);
    return (s > BW'(top)) ? top : s[CW-1:0];
  endfunction

  // Store slot of entry (i, j); recip selects the kept reciprocal of row i
  function automatic logic [32:0] cell_addr(input logic [CW-1:0] i, input logic [CW-1:0] j,
                                            input logic recip);
    logic          low;
    logic [CW-1:0] band;
    logic [31:0]   a;
    low  = recip || (j < i);
    band = recip ? '0 : ((j >= i) ? (j - i) : (i - j));
    a    = 32'(band) * 32'(DIM_MAX) + 32'(i);
    return {low, a};
  endfunction

  // ---------------------------------------------------------------- fields
  logic [2:0]        in_req;
  logic              in_fac;
  logic [4:0]        in_row;
  logic [4:0]        in_col;
  logic signed [31:0] in_val;
  logic              in_fire;

  assign in_req  = in_tuser[2:0];
  assign in_fac  = in_tuser[3];
  assign in_row  = in_tdata[4:0];
  assign in_col  = in_tdata[9:5];
  assign in_val  = $signed(in_tdata[41:10]);
  assign in_fire = in_tvalid && in_tready;

  // ---------------------------------------------------------------- state
  logic [5:0]          state_r, state_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                solve_r, solve_nxt;
  logic signed [31:0]  opr_r, opr_nxt;     // inverse, pivot, multiplier, rhs or diagonal
  logic signed [63:0]  acc_r, acc_nxt;
  logic signed [63:0]  prod_r;
  logic signed [31:0]  mul_a, mul_b;
  logic                prod_en;
  logic [CLR_W-1:0]    clr_r;
  logic                clr_act;

  logic                out_valid_r;
  logic signed [31:0]  out_val_r;
  logic [4:0]          out_idx_r;
  logic                out_last_r;
  logic [1:0]          out_st_r;
  logic                out_ld;
  logic signed [31:0]  out_val_nxt;
  logic [4:0]          out_idx_nxt;
  logic                out_last_nxt;
  logic [1:0]          out_st_nxt;
  logic                out_free;

  // store access requests
  logic [CW-1:0]       c_ri, c_rj;
  logic                c_rrec;
  logic                c_we;
  logic [CW-1:0]       c_wi, c_wj;
  logic                c_wrec;
  logic signed [31:0]  c_wd;
  logic [CW-1:0]       r_ri;
  logic                r_we;
  logic [CW-1:0]       r_wi;
  logic signed [31:0]  r_wd;
  logic [CW-1:0]       w_ri;
  logic                w_we;
  logic [CW-1:0]       w_wi;
  logic signed [31:0]  w_wd;

  blu_pkg::div_req_t   div_req;
  blu_pkg::div_rsp_t   div_rsp;

  logic signed [31:0]  cell_q;
  logic signed [31:0]  rhs_q;
  logic signed [31:0]  w_q;

  logic signed [6:0]   in_diff;
  logic                in_bad;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign clr_act   = (state_r == S_CLR);

  always_comb begin
    in_diff = $signed({2'b0, in_col}) - $signed({2'b0, in_row});
    in_bad  = (32'(in_row) >= 32'(n_eff)) || (32'(in_col) >= 32'(n_eff)) ||
              (in_diff > $signed({4'b0, nu})) || (in_diff < -$signed({4'b0, nl}));
  end

  blu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    solve_nxt    = solve_r;
    opr_nxt      = opr_r;
    acc_nxt      = acc_r;
    mul_a        = cell_q;
    mul_b        = opr_r;
    prod_en      = 1'b0;
    out_ld       = 1'b0;
    out_val_nxt  = '0;
    out_idx_nxt  = '0;
    out_last_nxt = 1'b1;
    out_st_nxt   = blu_pkg::ST_OK;
    c_ri         = i_r;
    c_rj         = j_r;
    c_rrec       = 1'b0;
    c_we         = 1'b0;
    c_wi         = i_r;
    c_wj         = j_r;
    c_wrec       = 1'b0;
    c_wd         = '0;
    r_ri         = i_r;
    r_we         = 1'b0;
    r_wi         = CW'(in_row);
    r_wd         = in_val;
    w_ri         = i_r;
    w_we         = 1'b0;
    w_wi         = i_r;
    w_wd         = '0;
    div_req      = '0;

    case (state_r)
      // zero the band and rhs stores one slot per cycle after reset
      S_CLR: begin
        if (32'(clr_r) == CLR_N - 1) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_fire) begin
          case (in_req)
            blu_pkg::REQ_WR_ENTRY: begin
              out_ld = 1'b1;
              if (in_bad) begin
                out_st_nxt = blu_pkg::ST_RANGE;
              end else begin
                c_we = 1'b1;
                c_wi = CW'(in_row);
                c_wj = CW'(in_col);
                c_wd = in_val;
              end
            end
            blu_pkg::REQ_RD_ENTRY: begin
              if (in_bad) begin
                out_ld     = 1'b1;
                out_st_nxt = blu_pkg::ST_RANGE;
              end else begin
                c_ri      = CW'(in_row);
                c_rj      = CW'(in_col);
                state_nxt = S_RDW;
              end
            end
            blu_pkg::REQ_WR_RHS: begin
              out_ld = 1'b1;
              if (32'(in_row) >= 32'(n_eff)) out_st_nxt = blu_pkg::ST_RANGE;
              else r_we = 1'b1;
            end
            blu_pkg::REQ_FACTOR: begin
              solve_nxt = 1'b0;
              i_nxt     = '0;
              state_nxt = S_FS_I;
            end
            blu_pkg::REQ_SOLVE: begin
              solve_nxt = 1'b1;
              i_nxt     = '0;
              state_nxt = in_fac ? S_SF_I : S_FS_I;
            end
            default: ;
          endcase
        end
      end

      S_RDW: begin
        out_ld      = 1'b1;
        out_val_nxt = cell_q;
        state_nxt   = S_IDLE;
      end

      // scale each row by the reciprocal of its diagonal
      S_FS_I: begin
        c_rj      = i_r;
        state_nxt = S_FS_D;
      end
      S_FS_D: begin
        if (cell_q == 32'sd0) begin
          out_ld     = 1'b1;
          out_st_nxt = blu_pkg::ST_PIVOT;
          state_nxt  = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = blu_pkg::Q_ONE;
          div_req.den   = cell_q;
          state_nxt     = S_FS_DIV;
        end
      end
      S_FS_DIV: begin
        if (div_rsp.done) begin
          opr_nxt   = div_rsp.quot;
          c_we      = 1'b1;
          c_wrec    = 1'b1;
          c_wd      = div_rsp.quot;
          j_nxt     = lo_b(i_r, nl);
          state_nxt = S_FS_J;
        end
      end
      S_FS_J: begin
        if (j_r > hi_b(i_r, nu, nm1)) begin
          c_we = 1'b1;
          c_wj = i_r;
          c_wd = blu_pkg::Q_ONE;
          if (i_r == nm1) begin
            k_nxt     = '0;
            state_nxt = S_E_K;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_FS_I;
          end
        end else begin
          state_nxt = S_FS_JM;
        end
      end
      S_FS_JM: begin
        prod_en   = 1'b1;
        state_nxt = S_FS_JR;
      end
      S_FS_JR: begin
        c_we      = 1'b1;
        c_wd      = blu_pkg::sat32(blu_pkg::mulq_rnd(prod_r));
        j_nxt     = j_r + CW'(1);
        state_nxt = S_FS_J;
      end

      // elimination below the diagonal
      S_E_K: begin
        if (k_r == n_eff) begin
          if (solve_r) begin
            i_nxt     = '0;
            state_nxt = S_SF_I;
          end else begin
            out_ld    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          i_nxt     = k_r + CW'(1);
          state_nxt = S_E_I;
        end
      end
      S_E_I: begin
        if (i_r > hi_b(k_r, nl, nm1)) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_E_K;
        end else begin
          c_ri      = k_r;
          c_rj      = k_r;
          state_nxt = S_E_P;
        end
      end
      S_E_P: begin
        if (cell_q == 32'sd0) begin
          out_ld     = 1'b1;
          out_st_nxt = blu_pkg::ST_PIVOT;
          state_nxt  = S_IDLE;
        end else begin
          opr_nxt   = cell_q;
          c_rj      = k_r;
          state_nxt = S_E_PW;
        end
      end
      S_E_PW: begin
        div_req.start = 1'b1;
        div_req.num   = cell_q;
        div_req.den   = opr_r;
        state_nxt     = S_E_DIV;
      end
      S_E_DIV: begin
        if (div_rsp.done) begin
          opr_nxt   = div_rsp.quot;
          c_we      = 1'b1;
          c_wj      = k_r;
          c_wd      = div_rsp.quot;
          j_nxt     = k_r + CW'(1);
          state_nxt = S_E_J;
        end
      end
      S_E_J: begin
        if (j_r > hi_b(k_r, nu, nm1)) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_E_I;
        end else begin
          c_ri      = k_r;
          state_nxt = S_E_JM;
        end
      end
      S_E_JM: begin
        prod_en   = 1'b1;
        mul_a     = opr_r;
        mul_b     = cell_q;
        state_nxt = S_E_JR;
      end
      S_E_JR: begin
        c_we      = 1'b1;
        c_wd      = blu_pkg::sat32(64'(cell_q) - blu_pkg::mulq_rnd(prod_r));
        j_nxt     = j_r + CW'(1);
        state_nxt = S_E_J;
      end

      // forward substitution
      S_SF_I: begin
        if (i_r == n_eff) begin
          i_nxt     = nm1;
          state_nxt = S_SB_I;
        end else begin
          state_nxt = S_SF_R;
        end
      end
      S_SF_R: begin
        opr_nxt   = rhs_q;
        c_rrec    = 1'b1;
        state_nxt = S_SF_L;
      end
      S_SF_L: begin
        prod_en   = 1'b1;
        mul_a     = opr_r;
        mul_b     = cell_q;
        state_nxt = S_SF_L2;
      end
      S_SF_L2: begin
        acc_nxt   = blu_pkg::mulq_rnd(prod_r);
        j_nxt     = lo_b(i_r, nl);
        state_nxt = S_SF_J;
      end
      S_SF_J: begin
        if (j_r >= i_r) begin
          w_we      = 1'b1;
          w_wd      = blu_pkg::sat32(acc_r);
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SF_I;
        end else begin
          w_ri      = j_r;
          state_nxt = S_SF_JM;
        end
      end
      S_SF_JM: begin
        prod_en   = 1'b1;
        mul_a     = cell_q;
        mul_b     = w_q;
        state_nxt = S_SF_JA;
      end
      S_SF_JA: begin
        acc_nxt   = acc_r - blu_pkg::mulq_rnd(prod_r);
        j_nxt     = j_r + CW'(1);
        state_nxt = S_SF_J;
      end

      // backward substitution
      S_SB_I: begin
        acc_nxt   = '0;
        j_nxt     = i_r + CW'(1);
        c_rj      = i_r;
        state_nxt = S_SB_D;
      end
      S_SB_D: begin
        opr_nxt   = cell_q;
        state_nxt = S_SB_J;
      end
      S_SB_J: begin
        if (j_r > hi_b(i_r, nu, nm1)) begin
          state_nxt = S_SB_W;
        end else begin
          w_ri      = j_r;
          state_nxt = S_SB_JM;
        end
      end
      S_SB_JM: begin
        prod_en   = 1'b1;
        mul_a     = cell_q;
        mul_b     = w_q;
        state_nxt = S_SB_JA;
      end
      S_SB_JA: begin
        acc_nxt   = acc_r + blu_pkg::mulq_rnd(prod_r);
        j_nxt     = j_r + CW'(1);
        state_nxt = S_SB_J;
      end
      S_SB_W: begin
        if (opr_r == 32'sd0) begin
          out_ld     = 1'b1;
          out_st_nxt = blu_pkg::ST_PIVOT;
          state_nxt  = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = blu_pkg::sat32(64'(w_q) - acc_r);
          div_req.den   = opr_r;
          state_nxt     = S_SB_DIV;
        end
      end
      S_SB_DIV: begin
        if (div_rsp.done) begin
          w_we = 1'b1;
          w_wd = div_rsp.quot;
          if (i_r == '0) begin
            state_nxt = S_EM_RD;
          end else begin
            i_nxt     = i_r - CW'(1);
            state_nxt = S_SB_I;
          end
        end
      end

      // emit the solution in order
      S_EM_RD: begin
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_val_nxt  = w_q;
          out_idx_nxt  = 5'(i_r);
          out_last_nxt = (i_r == nm1);
          if (i_r == nm1) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      solve_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      solve_r     <= solve_nxt;
      if (clr_act) clr_r <= clr_r + CLR_W'(1);
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    opr_r <= opr_nxt;
    acc_r <= acc_nxt;
    if (prod_en) prod_r <= mul_a * mul_b;
    if (out_ld) begin
      out_val_r  <= out_val_nxt;
      out_idx_r  <= out_idx_nxt;
      out_last_r <= out_last_nxt;
      out_st_r   <= out_st_nxt;
    end
  end

  // ---------------------------------------------------------------- stores
  logic signed [31:0] upper_mem [UD];
  logic signed [31:0] lower_mem [LD];
  logic signed [31:0] rhs_mem   [DIM_MAX];
  logic signed [31:0] work_mem  [DIM_MAX];

  logic [32:0]        ra;
  logic [32:0]        wa;
  logic [UAW-1:0]     u_ra, u_wa;
  logic [LAW-1:0]     l_ra, l_wa;

  // write side after the clearing pass mux
  logic               u_we, l_we, rh_we;
  logic [UAW-1:0]     u_wa_m;
  logic [LAW-1:0]     l_wa_m;
  logic [IW-1:0]      rh_wa;
  logic signed [31:0] st_wd, rh_wd;

  logic signed [31:0] u_q_r, l_q_r, rhs_q_r, w_q_r;
  logic               sel_low_r;

  always_comb begin
    ra   = cell_addr(c_ri, c_rj, c_rrec);
    wa   = cell_addr(c_wi, c_wj, c_wrec);
    u_ra = ra[UAW-1:0];
    l_ra = ra[LAW-1:0];
    u_wa = wa[UAW-1:0];
    l_wa = wa[LAW-1:0];
    if (clr_act) begin
      u_we   = (32'(clr_r) < UD);
      u_wa_m = clr_r[UAW-1:0];
      l_we   = (32'(clr_r) < LD);
      l_wa_m = clr_r[LAW-1:0];
      rh_we  = (32'(clr_r) < DIM_MAX);
      rh_wa  = clr_r[IW-1:0];
      st_wd  = '0;
      rh_wd  = '0;
    end else begin
      u_we   = c_we && !wa[32];
      u_wa_m = u_wa;
      l_we   = c_we && wa[32];
      l_wa_m = l_wa;
      rh_we  = r_we;
      rh_wa  = r_wi[IW-1:0];
      st_wd  = c_wd;
      rh_wd  = r_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (u_we)  upper_mem[u_wa_m] <= st_wd;
    if (l_we)  lower_mem[l_wa_m] <= st_wd;
    if (rh_we) rhs_mem[rh_wa] <= rh_wd;
    if (w_we)  work_mem[w_wi[IW-1:0]] <= w_wd;
    u_q_r     <= upper_mem[u_ra];
    l_q_r     <= lower_mem[l_ra];
    sel_low_r <= ra[32];
    rhs_q_r   <= rhs_mem[r_ri[IW-1:0]];
    w_q_r     <= work_mem[w_ri[IW-1:0]];
  end

  assign cell_q = sel_low_r ? l_q_r : u_q_r;
  assign rhs_q  = rhs_q_r;
  assign w_q    = w_q_r;

  // ---------------------------------------------------------------- outputs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_idx_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

endmodule

>>> rtl/blu_chk.sv
`timescale 1ns / 1ps

module blu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [3:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an error result ends its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != blu_pkg::ST_OK |-> out_tlast)
    else $error("error result without tlast");

  // no new request while a result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("ready while result pending");

  // an rhs write answers in the next cycle
  a_rhs_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[2:0] == blu_pkg::REQ_WR_RHS |=> out_tvalid && out_tlast)
    else $error("rhs write not answered");

endmodule

bind band_matrix_lu_solver_core blu_chk u_blu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
